// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file ehfx_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- sv/ehfx_pkg.sv -----
`timescale 1ns / 1ps

package ehfx_pkg;

   localparam int MAX_FRAME_BYTES = 16384;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SEL_W           = 4;
   localparam int BYTE_W          = 8;
   localparam int VALUE_W         = 48;
   localparam int LEN_W           = 15;
   localparam int RSP_W           = 80;

   localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

   localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
   localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
   localparam logic [POS_W-1:0] POS_IHL      = POS_W'(14);
   localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(23);
   localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_FRAME_BYTES);

   typedef enum logic [1:0] {
      BASE_ETH,
      BASE_IP,
      BASE_L4
   } base_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_IP,
      KIND_TCP,
      KIND_TCPUDP,
      KIND_ICMP
   } kind_type;

   typedef enum logic [SEL_W-1:0] {
      SEL_SRCMAC,
      SEL_DSTMAC,
      SEL_PROTO,
      SEL_SRCIP,
      SEL_DSTIP,
      SEL_IPID,
      SEL_TTL,
      SEL_SRCPORT,
      SEL_DSTPORT,
      SEL_SEQ,
      SEL_ACK,
      SEL_URGPTR,
      SEL_URG,
      SEL_WINDOW,
      SEL_ICMPTYPE,
      SEL_UNUSED
   } sel_type;

   typedef struct packed {
      base_type   base;
      logic [4:0] offset;
      logic [2:0] length;
      kind_type   kind;
   } field_desc_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [15:0]        ether_kind;
      logic [3:0]         ihl;
      logic [7:0]         proto;
      logic [3:0]         tcp_words;
      logic [VALUE_W-1:0] cap_field;
      logic [3:0]         cap_bytes;
   } frame_type;

   function automatic field_desc_type field_desc(sel_type sel);
      field_desc_type d;
      case (sel)
         SEL_SRCMAC:   d = '{BASE_ETH, 5'd6,  3'd6, KIND_NONE};
         SEL_DSTMAC:   d = '{BASE_ETH, 5'd0,  3'd6, KIND_NONE};
         SEL_PROTO:    d = '{BASE_IP,  5'd9,  3'd1, KIND_IP};
         SEL_SRCIP:    d = '{BASE_IP,  5'd12, 3'd4, KIND_IP};
         SEL_DSTIP:    d = '{BASE_IP,  5'd16, 3'd4, KIND_IP};
         SEL_IPID:     d = '{BASE_IP,  5'd4,  3'd2, KIND_IP};
         SEL_TTL:      d = '{BASE_IP,  5'd8,  3'd1, KIND_IP};
         SEL_SRCPORT:  d = '{BASE_L4,  5'd0,  3'd2, KIND_TCPUDP};
         SEL_DSTPORT:  d = '{BASE_L4,  5'd2,  3'd2, KIND_TCPUDP};
         SEL_SEQ:      d = '{BASE_L4,  5'd4,  3'd4, KIND_TCP};
         SEL_ACK:      d = '{BASE_L4,  5'd8,  3'd4, KIND_TCP};
         SEL_URGPTR:   d = '{BASE_L4,  5'd18, 3'd2, KIND_TCP};
         SEL_URG:      d = '{BASE_L4,  5'd13, 3'd1, KIND_TCP};
         SEL_WINDOW:   d = '{BASE_L4,  5'd14, 3'd2, KIND_TCP};
         SEL_ICMPTYPE: d = '{BASE_L4,  5'd0,  3'd1, KIND_ICMP};
         default:      d = '{BASE_ETH, 5'd0,  3'd0, KIND_NONE};
      endcase
      return d;
   endfunction

   // L4 header start: 14 + 4 * IHL (max 74)
   function automatic logic [7:0] l4_start(logic [3:0] ihl);
      return ETH_HDR_BYTES + {2'b00, ihl, 2'b00};
   endfunction

   function automatic logic [POS_W-1:0] to_pos(logic [7:0] v);
      return {{(POS_W - 8){1'b0}}, v};
   endfunction

endpackage

// ----- sv/ehfx_frame.sv -----
`timescale 1ns / 1ps

module ehfx_frame (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        last,
   input  logic [ehfx_pkg::BYTE_W-1:0] frame_byte,
   input  ehfx_pkg::sel_type           field_select,
   output ehfx_pkg::frame_type         upd
);

   ehfx_pkg::frame_type      cur_ff;
   ehfx_pkg::frame_type      cur_in;
   ehfx_pkg::field_desc_type desc;
   logic [7:0]               l4;
   logic [7:0]               base_pos;
   logic [7:0]               start;
   logic [7:0]               stop;

   always_comb begin
      upd      = cur_ff;
      desc     = ehfx_pkg::field_desc(field_select);
      l4       = ehfx_pkg::l4_start(cur_ff.ihl);
      base_pos = 8'd0;
      start    = 8'd0;
      stop     = 8'd0;
      if (cur_ff.pos < ehfx_pkg::POS_LIMIT) begin
         if (cur_ff.pos == ehfx_pkg::POS_IHL) begin
            upd.ihl = frame_byte[3:0];
         end
         l4 = ehfx_pkg::l4_start(upd.ihl);
         if (cur_ff.pos == ehfx_pkg::POS_ETYPE_HI || cur_ff.pos == ehfx_pkg::POS_ETYPE_LO) begin
            upd.ether_kind = {cur_ff.ether_kind[7:0], frame_byte};
         end
         if (cur_ff.pos == ehfx_pkg::POS_PROTO) begin
            upd.proto = frame_byte;
         end
         if (cur_ff.pos == ehfx_pkg::to_pos(l4 + 8'd12)) begin
            upd.tcp_words = frame_byte[7:4];
         end
         case (desc.base)
            ehfx_pkg::BASE_IP: base_pos = ehfx_pkg::ETH_HDR_BYTES;
            ehfx_pkg::BASE_L4: base_pos = l4;
            default:           base_pos = 8'd0;
         endcase
         start = base_pos + {3'b000, desc.offset};
         stop  = start + {5'b00000, desc.length};
         if (cur_ff.pos >= ehfx_pkg::to_pos(start) && cur_ff.pos < ehfx_pkg::to_pos(stop)) begin
            upd.cap_field = {cur_ff.cap_field[ehfx_pkg::VALUE_W-9:0], frame_byte};
            if (cur_ff.cap_bytes != 4'hF) begin
               upd.cap_bytes = cur_ff.cap_bytes + 4'd1;
            end
         end
         upd.pos = cur_ff.pos + ehfx_pkg::POS_W'(1);
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (step) begin
         cur_in = last ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

endmodule

// ----- sv/ehfx_result.sv -----
`timescale 1ns / 1ps

module ehfx_result (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  ehfx_pkg::frame_type        upd,
   input  ehfx_pkg::sel_type          field_select,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [ehfx_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_free
);

   ehfx_pkg::field_desc_type         desc;
   logic                             ip;
   logic                             is_tcp;
   logic                             kind_ok;
   logic                             present;
   logic [ehfx_pkg::VALUE_W-1:0]     mask;
   logic [ehfx_pkg::VALUE_W-1:0]     value;
   logic [7:0]                       l4;
   logic [7:0]                       poff;
   logic                             ppres;
   logic [ehfx_pkg::LEN_W-1:0]       plen;
   logic                             rsp_tvalid_ff;
   logic                             rsp_tvalid_in;
   logic [ehfx_pkg::RSP_W-1:0]       rsp_data_ff;
   logic [ehfx_pkg::RSP_W-1:0]       rsp_data_in;

   always_comb begin
      desc   = ehfx_pkg::field_desc(field_select);
      ip     = upd.ether_kind == ehfx_pkg::ETHERTYPE_IPV4;
      is_tcp = ip && upd.proto == ehfx_pkg::PROTO_TCP;
      case (desc.kind)
         ehfx_pkg::KIND_NONE:   kind_ok = 1'b1;
         ehfx_pkg::KIND_IP:     kind_ok = ip;
         ehfx_pkg::KIND_TCP:    kind_ok = is_tcp;
         ehfx_pkg::KIND_TCPUDP: kind_ok = is_tcp || (ip && upd.proto == ehfx_pkg::PROTO_UDP);
         ehfx_pkg::KIND_ICMP:   kind_ok = ip && upd.proto == ehfx_pkg::PROTO_ICMP;
         default:               kind_ok = 1'b0;
      endcase
      present = field_select != ehfx_pkg::SEL_UNUSED && kind_ok
                && upd.cap_bytes == {1'b0, desc.length};

      if (desc.length >= 3'd6) begin
         mask = '1;
      end else begin
         mask = (ehfx_pkg::VALUE_W'(1) << {desc.length, 3'b000}) - ehfx_pkg::VALUE_W'(1);
      end
      value = upd.cap_field & mask;
      if (field_select == ehfx_pkg::SEL_URG) begin
         value = {{(ehfx_pkg::VALUE_W - 1){1'b0}}, value[5]};
      end
      if (!present) begin
         value = '0;
      end

      l4    = ehfx_pkg::l4_start(upd.ihl);
      ppres = 1'b0;
      poff  = 8'd0;
      if (is_tcp && upd.pos >= ehfx_pkg::to_pos(l4 + 8'd13)) begin
         ppres = 1'b1;
         poff  = l4 + {2'b00, upd.tcp_words, 2'b00};
      end else if (ip && upd.proto == ehfx_pkg::PROTO_UDP) begin
         ppres = 1'b1;
         poff  = l4 + 8'd8;
      end
      plen = '0;
      if (ppres && upd.pos > ehfx_pkg::to_pos(poff)) begin
         plen = ehfx_pkg::LEN_W'(upd.pos - ehfx_pkg::to_pos(poff));
      end

      rsp_data_in = {ppres, plen, ehfx_pkg::LEN_W'(poff), present, value};
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

endmodule

// ----- sv/eth_ipv4_l4_header_field_extractor.sv -----
`timescale 1ns / 1ps
// An accepted last beat is held in the s1 input register, then its result is loaded into the rsp register.
// Throughput: one beat per cycle; the input register and the result register
// are both one deep, so a held result stalls req only on the next last beat.
// Reset (synchronous): clears frame state, field_select and both valids.
// Per-frame state also clears after every last beat.

module eth_ipv4_l4_header_field_extractor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ehfx_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] frame_byte
   input  logic                         req_tlast,   // end_of_frame
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [47:0] field_value, [48] field_present, [63:49] payload_offset,
   // [78:64] payload_length, [79] payload_present
   output logic [ehfx_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_wr_en,
   input  logic [ehfx_pkg::SEL_W-1:0]   csr_wr_data  // field_select
);

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic                        s1_last_ff;
   logic [ehfx_pkg::BYTE_W-1:0] s1_byte_ff;
   ehfx_pkg::sel_type           sel_ff;
   ehfx_pkg::frame_type         upd;
   logic                        rsp_free;
   logic                        advance;
   logic                        req_beat;

   assign advance    = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_tready = !s1_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sel_ff      <= ehfx_pkg::SEL_SRCMAC;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wr_en) begin
            sel_ff <= ehfx_pkg::sel_type'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   ehfx_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .last         (s1_last_ff),
      .frame_byte   (s1_byte_ff),
      .field_select (sel_ff),
      .upd          (upd)
   );

   ehfx_result u_result (
      .clock        (clock),
      .reset        (reset),
      .load         (advance && s1_last_ff),
      .upd          (upd),
      .field_select (sel_ff),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_free     (rsp_free)
   );

endmodule

// ----- sv/ehfx_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ehfx_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ehfx_pkg::RSP_W-1:0] rsp_tdata
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")
   `ASSERT_IMPL(a_absent_zero, clock, reset, rsp_tvalid && !rsp_tdata[48], rsp_tdata[47:0] == 48'd0, "absent field has nonzero value")
   `ASSERT_IMPL(a_no_payload_zero, clock, reset, rsp_tvalid && !rsp_tdata[79], rsp_tdata[78:49] == 30'd0, "absent payload has nonzero offset or length")
   `ASSERT_IMPL(a_payload_range, clock, reset, rsp_tvalid && rsp_tdata[79], rsp_tdata[63:49] >= 15'd14 && rsp_tdata[63:49] <= 15'd134, "payload offset out of range")

endmodule

bind eth_ipv4_l4_header_field_extractor ehfx_checker u_ehfx_checker (.*);

// ----- tb/ehfx_parse_checker.sv -----
`timescale 1ns / 1ps

module ehfx_parse_checker
   import ehfx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // [7:0] frame_byte
   input  logic               req_tlast,   // end_of_frame
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [47:0] field_value, [48] field_present, [63:49] payload_offset,
   // [78:64] payload_length, [79] payload_present
   input  logic [RSP_W-1:0]   rsp_tdata,
   input  logic               csr_wr_en,
   input  logic [SEL_W-1:0]   csr_wr_data, // field_select
   output int                 failures,
   output int                 outstanding,
   output int                 results_seen
);

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               present;
      logic [LEN_W-1:0]   poff;
      logic [LEN_W-1:0]   plen;
      logic               ppres;
   } frame_result_t;

   sel_type            field_sel;
   int unsigned        byte_pos;
   logic [15:0]        etype_q;
   logic [3:0]         ihl_q;
   logic [7:0]         proto_q;
   logic [3:0]         doff_q;
   logic [VALUE_W-1:0] cap_q;
   int unsigned        cap_n;
   frame_result_t      expected_results[$];

   task automatic clear_parse();
      byte_pos = 0;
      etype_q  = '0;
      ihl_q    = '0;
      proto_q  = '0;
      doff_q   = '0;
      cap_q    = '0;
      cap_n    = 0;
   endtask

   function automatic void field_layout(input sel_type s, output base_type base,
                                        output int unsigned off, output int unsigned len,
                                        output kind_type kind);
      base = BASE_L4;
      kind = KIND_TCP;
      off  = 0;
      len  = 0;
      case (s)
         SEL_SRCMAC:   begin base = BASE_ETH; off = 6;  len = 6; kind = KIND_NONE;   end
         SEL_DSTMAC:   begin base = BASE_ETH; off = 0;  len = 6; kind = KIND_NONE;   end
         SEL_PROTO:    begin base = BASE_IP;  off = 9;  len = 1; kind = KIND_IP;     end
         SEL_SRCIP:    begin base = BASE_IP;  off = 12; len = 4; kind = KIND_IP;     end
         SEL_DSTIP:    begin base = BASE_IP;  off = 16; len = 4; kind = KIND_IP;     end
         SEL_IPID:     begin base = BASE_IP;  off = 4;  len = 2; kind = KIND_IP;     end
         SEL_TTL:      begin base = BASE_IP;  off = 8;  len = 1; kind = KIND_IP;     end
         SEL_SRCPORT:  begin off = 0;  len = 2; kind = KIND_TCPUDP; end
         SEL_DSTPORT:  begin off = 2;  len = 2; kind = KIND_TCPUDP; end
         SEL_SEQ:      begin off = 4;  len = 4; end
         SEL_ACK:      begin off = 8;  len = 4; end
         SEL_URGPTR:   begin off = 18; len = 2; end
         SEL_URG:      begin off = 13; len = 1; end
         SEL_WINDOW:   begin off = 14; len = 2; end
         SEL_ICMPTYPE: begin off = 0;  len = 1; kind = KIND_ICMP; end
         default:      begin base = BASE_ETH; kind = KIND_NONE; end
      endcase
   endfunction

   function automatic logic kind_met(input kind_type k);
      logic is_ip;
      is_ip = (etype_q == ETHERTYPE_IPV4);
      case (k)
         KIND_NONE:   return 1'b1;
         KIND_IP:     return is_ip;
         KIND_TCP:    return is_ip && proto_q == PROTO_TCP;
         KIND_TCPUDP: return is_ip && (proto_q == PROTO_TCP || proto_q == PROTO_UDP);
         default:     return is_ip && proto_q == PROTO_ICMP;
      endcase
   endfunction

   function automatic void advance_parse(input logic [7:0] b);
      base_type    base;
      kind_type    kind;
      int unsigned off, len, l4, start;
      if (byte_pos >= MAX_FRAME_BYTES) return;
      if (byte_pos == POS_IHL) ihl_q = b[3:0];
      l4 = ETH_HDR_BYTES + 4 * ihl_q;
      if (byte_pos == POS_ETYPE_HI || byte_pos == POS_ETYPE_LO) etype_q = {etype_q[7:0], b};
      if (byte_pos == POS_PROTO) proto_q = b;
      if (byte_pos == l4 + 12) doff_q = b[7:4];
      field_layout(field_sel, base, off, len, kind);
      case (base)
         BASE_ETH: start = off;
         BASE_IP:  start = ETH_HDR_BYTES + off;
         default:  start = l4 + off;
      endcase
      if (byte_pos >= start && byte_pos < start + len) begin
         cap_q = {cap_q[VALUE_W-9:0], b};
         if (cap_n < 15) cap_n++;
      end
      byte_pos++;
   endfunction

   function automatic frame_result_t close_frame();
      frame_result_t r;
      base_type      base;
      kind_type      kind;
      int unsigned   off, len, l4, poff;
      logic          is_ip;
      field_layout(field_sel, base, off, len, kind);
      r.value   = '0;
      r.present = 1'b0;
      r.poff    = '0;
      r.plen    = '0;
      r.ppres   = 1'b0;
      poff      = 0;
      if (field_sel != SEL_UNUSED && kind_met(kind) && cap_n == len) begin
         r.present = 1'b1;
         r.value   = cap_q;
         if (len < 6) r.value = r.value & ((VALUE_W'(1) << (8 * len)) - VALUE_W'(1));
         if (field_sel == SEL_URG) r.value = VALUE_W'(r.value[5]);
      end
      is_ip = (etype_q == ETHERTYPE_IPV4);
      l4    = ETH_HDR_BYTES + 4 * ihl_q;
      if (is_ip && proto_q == PROTO_TCP && byte_pos >= l4 + 13) begin
         r.ppres = 1'b1;
         poff    = l4 + 4 * doff_q;
      end else if (is_ip && proto_q == PROTO_UDP) begin
         r.ppres = 1'b1;
         poff    = l4 + 8;
      end
      if (r.ppres) begin
         r.poff = LEN_W'(poff);
         r.plen = (byte_pos > poff) ? LEN_W'(byte_pos - poff) : '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("%0t: result %0d %s mismatch: got %0h, expected %0h",
               $realtime, results_seen, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin : monitor
      frame_result_t want;
      if (reset) begin
         field_sel = SEL_SRCMAC;
         clear_parse();
         expected_results.delete();
         failures     = 0;
         results_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[47:0], '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[47:0] !== want.value)
                  report_mismatch("field_value", rsp_tdata[47:0], want.value);
               if (rsp_tdata[48] !== want.present)
                  report_mismatch("field_present", rsp_tdata[48], want.present);
               if (rsp_tdata[63:49] !== want.poff)
                  report_mismatch("payload_offset", rsp_tdata[63:49], want.poff);
               if (rsp_tdata[78:64] !== want.plen)
                  report_mismatch("payload_length", rsp_tdata[78:64], want.plen);
               if (rsp_tdata[79] !== want.ppres)
                  report_mismatch("payload_present", rsp_tdata[79], want.ppres);
            end
            results_seen++;
         end
         if (csr_wr_en) field_sel = sel_type'(csr_wr_data);
         if (req_tvalid && req_tready) begin
            advance_parse(req_tdata);
            if (req_tlast) begin
               expected_results.push_back(close_frame());
               clear_parse();
            end
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ----- tb/eth_ipv4_l4_header_field_extractor_tb.sv -----
`timescale 1ns / 1ps

module eth_ipv4_l4_header_field_extractor_tb;
   import ehfx_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   typedef enum {
      SHAPE_TCP,
      SHAPE_UDP,
      SHAPE_ICMP,
      SHAPE_IP_OTHER,
      SHAPE_NON_IP,
      SHAPE_NOISE
   } shape_t;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_tvalid   = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata    = '0;
   logic               req_tlast    = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready   = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en    = 1'b0;
   logic [SEL_W-1:0]   csr_wr_data  = '0;

   logic               calm         = 1'b0;
   logic               hold_request = 1'b0;
   int                 hold_left    = 0;
   int                 cycle_count  = 0;
   int                 failures;
   int                 outstanding;
   int                 results_seen;
   int                 frames_sent  = 0;
   int                 bytes_sent   = 0;
   int                 frame_l4;
   logic [7:0]         frame_buf[$];

   eth_ipv4_l4_header_field_extractor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ehfx_parse_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .failures     (failures),
      .outstanding  (outstanding),
      .results_seen (results_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
         $display("eth_ipv4_l4_header_field_extractor_tb failed");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 16);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eop);
      if (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eop;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_span(input int first, input int stop, input logic mark_end);
      for (int i = first; i < stop; i++) send_byte(frame_buf[i], mark_end && i == stop - 1);
      if (mark_end) frames_sent++;
   endtask

   task automatic send_frame();
      send_span(0, frame_buf.size(), 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_select(input sel_type s);
      csr_wr_data <= s;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic make_frame(input shape_t shape, input bit may_cut, input int ihl_pick);
      int          ihl, doff, hdr_end, len, cut;
      logic [7:0]  proto;
      logic [15:0] etype;
      frame_buf.delete();
      if (shape == SHAPE_NOISE) begin
         len = $urandom_range(1, 80);
         repeat (len) frame_buf.push_back(8'($urandom));
         return;
      end
      ihl  = (ihl_pick >= 0) ? ihl_pick :
             (($urandom_range(99) < 80) ? 5 : $urandom_range(0, 15));
      doff = ($urandom_range(99) < 80) ? 5 : $urandom_range(0, 15);
      frame_l4 = ETH_HDR_BYTES + 4 * ihl;
      hdr_end  = frame_l4 + 8;
      case (shape)
         SHAPE_TCP: begin
            proto   = PROTO_TCP;
            hdr_end = frame_l4 + ((doff > 5) ? 4 * doff : 20);
         end
         SHAPE_UDP:  proto = PROTO_UDP;
         SHAPE_ICMP: proto = PROTO_ICMP;
         default:    proto = 8'($urandom);
      endcase
      len = hdr_end + $urandom_range(0, 24);
      if (len <= POS_PROTO) len = POS_PROTO + 1;
      repeat (len) frame_buf.push_back(8'($urandom));
      if (shape == SHAPE_NON_IP) begin
         case ($urandom_range(2))
            0:       etype = 16'h0008;
            1:       etype = 16'h0801;
            default: etype = 16'($urandom);
         endcase
      end else begin
         etype = ETHERTYPE_IPV4;
      end
      frame_buf[POS_ETYPE_HI] = etype[15:8];
      frame_buf[POS_ETYPE_LO] = etype[7:0];
      frame_buf[POS_IHL]   = {(($urandom_range(99) < 90) ? 4'd4 : 4'($urandom)), 4'(ihl)};
      frame_buf[POS_PROTO] = proto;
      if (shape == SHAPE_TCP) frame_buf[frame_l4 + 12] = {4'(doff), 4'($urandom)};
      if (may_cut && $urandom_range(99) < 25) begin
         cut = $urandom_range(1, len);
         while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
   endtask

   function automatic shape_t pick_shape();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return SHAPE_TCP;
      if (r < 55) return SHAPE_UDP;
      if (r < 67) return SHAPE_ICMP;
      if (r < 77) return SHAPE_IP_OTHER;
      if (r < 87) return SHAPE_NON_IP;
      return SHAPE_NOISE;
   endfunction

   initial begin
      int phase, rand_frames, rand_bytes;
      sel_type s;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset select (srcmac): one-byte frame, all-zero and all-ones frames
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      send_frame();
      frame_buf.delete();
      repeat (60) frame_buf.push_back(8'h00);
      send_frame();
      frame_buf.delete();
      repeat (60) frame_buf.push_back(8'hFF);
      send_frame();
      drain();

      write_select(SEL_URG);
      make_frame(SHAPE_TCP, 1'b0, 5);
      frame_buf[frame_l4 + 13] = frame_buf[frame_l4 + 13] | 8'h20;
      send_frame();
      // select switches while a frame is half done
      make_frame(SHAPE_TCP, 1'b0, 5);
      send_span(0, 30, 1'b0);
      drain();
      write_select(SEL_WINDOW);
      send_span(30, frame_buf.size(), 1'b1);
      drain();

      // zero IHL: L4 header overlaps the IPv4 header
      write_select(SEL_ICMPTYPE);
      make_frame(SHAPE_ICMP, 1'b0, 5);
      send_frame();
      make_frame(SHAPE_ICMP, 1'b0, 0);
      send_frame();
      drain();
      write_select(SEL_SRCPORT);
      make_frame(SHAPE_TCP, 1'b0, 0);
      send_frame();
      drain();

      // oversized frame, last beat past the length limit
      write_select(SEL_DSTMAC);
      make_frame(SHAPE_TCP, 1'b0, 5);
      while (frame_buf.size() < MAX_FRAME_BYTES + 16) frame_buf.push_back(8'($urandom));
      send_frame();
      drain();

      // long receiver hold-off with tiny frames and UDP frames to back the block up
      write_select(SEL_SRCPORT);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      repeat (40) begin
         if ($urandom_range(1) == 0) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
         end else begin
            make_frame(SHAPE_UDP, 1'b1, -1);
         end
         send_frame();
      end
      drain();

      // random phases, first pass walks every select in order
      phase       = 0;
      rand_frames = 0;
      rand_bytes  = bytes_sent;
      while (phase < 16 || bytes_sent - rand_bytes < 2000 || rand_frames < 48) begin
         s = (phase < 16) ? sel_type'(phase) : sel_type'($urandom_range(0, 15));
         write_select(s);
         calm <= (phase == 5);
         repeat ($urandom_range(2, 4)) begin
            make_frame(pick_shape(), 1'b1, -1);
            send_frame();
            rand_frames++;
         end
         drain();
         phase++;
      end
      calm <= 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("covered %0d frames / %0d beats over all 16 selects, %0d results checked",
               frames_sent, bytes_sent, results_seen);
      $display("incl. one-byte, oversized and zero-IHL frames, mid-frame select change, hold-off");
      if (failures == 0) begin
         $display("eth_ipv4_l4_header_field_extractor_tb passed");
      end else begin
         $display("eth_ipv4_l4_header_field_extractor_tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ehfx_pkg.sv
sv/ehfx_frame.sv
sv/ehfx_result.sv
sv/eth_ipv4_l4_header_field_extractor.sv
sv/ehfx_checker.sv
tb/ehfx_parse_checker.sv
tb/eth_ipv4_l4_header_field_extractor_tb.sv
